@@ rtl/pbts_pkg.sv @@
// Shared types and constants of the priority bitmap task scheduler.
package pbts_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      CMD_CREATE = 3'd0,
      CMD_DELAY  = 3'd1,
      CMD_TICK   = 3'd2,
      CMD_LOCK   = 3'd3,
      CMD_UNLOCK = 3'd4
   } command_type;

   localparam int          CMD_W    = 3;
   localparam int          PRIO_W   = 5;
   localparam int          LOCK_W   = 8;
   localparam logic [7:0]  LOCK_MAX = 8'd255;

endpackage

@@ rtl/pbts_delay_ram.sv @@
// Per-level delay counter memory with reset-cleared valid bits and a registered read.
module pbts_delay_ram #(
   parameter int DEPTH = 32,
   parameter int AW    = 5,
   parameter int DW    = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic          clr,
   input  logic [AW-1:0] caddr,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0]    mem [DEPTH];
   logic [DEPTH-1:0] vld_ff;
   logic [DEPTH-1:0] vld_in;
   logic [DW-1:0]    rd_data_ff;
   logic             rd_vld_ff;

   // An entry that has never been written, or was cleared, reads as zero.
   always_comb begin
      vld_in = vld_ff;
      if (clr) begin
         vld_in[caddr] = 1'b0;
      end
      if (we) begin
         vld_in[waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rd_data_ff <= mem[raddr];
         rd_vld_ff  <= vld_ff[raddr];
      end
   end

   assign rdata = rd_vld_ff ? rd_data_ff : '0;

endmodule

@@ rtl/priority_bitmap_task_scheduler.sv @@
// Top level of the priority bitmap task scheduler.
//
// One command transaction enters on the req_ channel (valid/ready) and exactly
// one result transaction leaves on the rsp_ channel, carrying the switch flag,
// the level now current and the lock count after the command.
// Create, lock, unknown commands and an unlock that does not bring the lock count
// from one to zero go straight to the done state, which loads the output register.
// Delay, tick and an unlock that reaches zero pass through the walk state first:
// a sequencer walks every level once through the delay counter memory, one level
// per cycle behind its registered read port, sharing one decrementer and tracking
// the lowest ready level as it goes.
// One command is handled at a time; req_ready is high only while the block is
// idle. The result sits in an output register, so the next command is taken
// while an earlier result still waits on rsp_ready; a stalled receiver only
// holds the block once a second result is finished.
// Synchronous reset leaves only the idle level (PRIO_LEVELS-1) present, ready
// and current, all delay counters zero and the lock count zero.
module priority_bitmap_task_scheduler
   import pbts_pkg::*;
#(
   parameter int PRIO_LEVELS = 32,
   parameter int DELAY_BITS  = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CMD_W-1:0]  req_command,
   input  logic [PRIO_W-1:0] req_prio,
   input  logic [31:0]       req_delay_ticks,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_switch_request,
   output logic [PRIO_W-1:0] rsp_next_prio,
   output logic [LOCK_W-1:0] rsp_lock_level
);

   localparam int LW = $clog2(PRIO_LEVELS);
   localparam int PW = ((LW > PRIO_W) ? LW : PRIO_W) + 1;
   localparam logic [LW-1:0]          LAST = LW'(PRIO_LEVELS - 1);
   localparam logic [PRIO_LEVELS-1:0] IDLE_BIT = {1'b1, {(PRIO_LEVELS - 1){1'b0}}};

   state_type               state_ff, state_in;
   logic [CMD_W-1:0]        cmd_ff, cmd_in;
   logic [PRIO_LEVELS-1:0]  ready_ff, ready_in;
   logic [PRIO_LEVELS-1:0]  present_ff, present_in;
   logic [LOCK_W-1:0]       lock_ff, lock_in;
   logic [LW-1:0]           cur_ff, cur_in;
   logic                    found_ff, found_in;
   logic [LW-1:0]           win_ff, win_in;
   logic                    sched_ff, sched_in;
   logic [LW-1:0]           rd_idx_ff, rd_idx_in;
   logic                    issue_ff, issue_in;
   logic                    p_valid_ff, p_valid_in;
   logic [LW-1:0]           p_idx_ff, p_idx_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_sw_ff, rsp_sw_in;
   logic [PRIO_W-1:0]       rsp_prio_ff, rsp_prio_in;
   logic [LOCK_W-1:0]       rsp_lock_ff, rsp_lock_in;

   logic                    ram_we;
   logic [LW-1:0]           ram_waddr;
   logic [DELAY_BITS-1:0]   ram_wdata;
   logic                    ram_clr;
   logic [LW-1:0]           ram_caddr;
   logic                    ram_re;
   logic [DELAY_BITS-1:0]   ram_rdata;

   logic [PW-1:0]           prio_ext;
   logic                    accept;
   logic                    out_free;
   logic                    lvl_ready;
   logic                    do_switch;

   assign prio_ext  = PW'(req_prio);
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   pbts_delay_ram #(
      .DEPTH (PRIO_LEVELS),
      .AW    (LW),
      .DW    (DELAY_BITS)
   ) u_delay_ram (
      .clock (clock),
      .reset (reset),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .clr   (ram_clr),
      .caddr (ram_caddr),
      .re    (ram_re),
      .raddr (rd_idx_ff),
      .rdata (ram_rdata)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_command)
                  CMD_DELAY, CMD_TICK: state_in = ST_WALK;
                  CMD_UNLOCK: begin
                     state_in = (lock_ff == LOCK_W'(1)) ? ST_WALK : ST_DONE;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_WALK: begin
            if (p_valid_ff && (p_idx_ff == LAST)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath control and register updates.
   always_comb begin
      cmd_in       = cmd_ff;
      ready_in     = ready_ff;
      present_in   = present_ff;
      lock_in      = lock_ff;
      cur_in       = cur_ff;
      found_in     = found_ff;
      win_in       = win_ff;
      sched_in     = sched_ff;
      rd_idx_in    = rd_idx_ff;
      issue_in     = issue_ff;
      p_valid_in   = 1'b0;
      p_idx_in     = p_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_sw_in    = rsp_sw_ff;
      rsp_prio_in  = rsp_prio_ff;
      rsp_lock_in  = rsp_lock_ff;
      ram_we       = 1'b0;
      ram_waddr    = p_idx_ff;
      ram_wdata    = ram_rdata - DELAY_BITS'(1);
      ram_clr      = 1'b0;
      ram_caddr    = LW'(prio_ext);
      ram_re       = 1'b0;
      lvl_ready    = ready_ff[p_idx_ff];
      do_switch    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in    = req_command;
               found_in  = 1'b0;
               sched_in  = 1'b0;
               rd_idx_in = '0;
               issue_in  = 1'b1;
               case (req_command)
                  CMD_CREATE: begin
                     if (prio_ext < PW'(PRIO_LEVELS)) begin
                        present_in[LW'(prio_ext)] = 1'b1;
                        ready_in[LW'(prio_ext)]   = 1'b1;
                        ram_clr                   = 1'b1;
                     end
                  end
                  CMD_DELAY: begin
                     ram_we           = 1'b1;
                     ram_waddr        = cur_ff;
                     ram_wdata        = req_delay_ticks[DELAY_BITS-1:0];
                     ready_in[cur_ff] = 1'b0;
                     sched_in         = 1'b1;
                  end
                  CMD_TICK: sched_in = 1'b1;
                  CMD_LOCK: begin
                     if (lock_ff != LOCK_MAX) begin
                        lock_in = lock_ff + LOCK_W'(1);
                     end
                  end
                  CMD_UNLOCK: begin
                     if (lock_ff != '0) begin
                        lock_in  = lock_ff - LOCK_W'(1);
                        sched_in = (lock_ff == LOCK_W'(1));
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_WALK: begin
            // Read of the next level overlaps the update of the previous one.
            if (issue_ff) begin
               ram_re     = 1'b1;
               p_valid_in = 1'b1;
               p_idx_in   = rd_idx_ff;
               rd_idx_in  = rd_idx_ff + LW'(1);
               if (rd_idx_ff == LAST) begin
                  issue_in = 1'b0;
               end
            end
            if (p_valid_ff) begin
               if ((cmd_ff == CMD_TICK) && present_ff[p_idx_ff]) begin
                  if (ram_rdata != '0) begin
                     ram_we = 1'b1;
                  end else begin
                     lvl_ready          = 1'b1;
                     ready_in[p_idx_ff] = 1'b1;
                  end
               end
               // Levels arrive in ascending order, so the first ready one wins.
               if (!found_ff && lvl_ready) begin
                  found_in = 1'b1;
                  win_in   = p_idx_ff;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               do_switch    = sched_ff && (lock_ff == '0) && found_ff && (win_ff != cur_ff);
               cur_in       = do_switch ? win_ff : cur_ff;
               rsp_valid_in = 1'b1;
               rsp_sw_in    = do_switch;
               rsp_prio_in  = PRIO_W'(do_switch ? win_ff : cur_ff);
               rsp_lock_in  = lock_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ready_ff     <= IDLE_BIT;
         present_ff   <= IDLE_BIT;
         lock_ff      <= '0;
         cur_ff       <= LAST;
         issue_ff     <= 1'b0;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ready_ff     <= ready_in;
         present_ff   <= present_in;
         lock_ff      <= lock_in;
         cur_ff       <= cur_in;
         issue_ff     <= issue_in;
         p_valid_ff   <= p_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      found_ff    <= found_in;
      win_ff      <= win_in;
      sched_ff    <= sched_in;
      rd_idx_ff   <= rd_idx_in;
      p_idx_ff    <= p_idx_in;
      rsp_sw_ff   <= rsp_sw_in;
      rsp_prio_ff <= rsp_prio_in;
      rsp_lock_ff <= rsp_lock_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_switch_request = rsp_sw_ff;
   assign rsp_next_prio      = rsp_prio_ff;
   assign rsp_lock_level     = rsp_lock_ff;

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the priority bitmap task scheduler.
`timescale 1ns / 1ps

module tb
   import pbts_pkg::*;
;

   localparam int LEVELS      = 32;
   localparam int DELAY_W     = 32;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 40;

   localparam logic [PRIO_W-1:0] IDLE_LEVEL      = PRIO_W'(LEVELS - 1);
   localparam logic [CMD_W-1:0]  CMD_SPARE_FIRST = 3'd5;
   localparam logic [CMD_W-1:0]  CMD_SPARE_MID   = 3'd6;
   localparam logic [CMD_W-1:0]  CMD_SPARE_LAST  = 3'd7;

   typedef struct packed {
      logic              switch_request;
      logic [PRIO_W-1:0] next_prio;
      logic [LOCK_W-1:0] lock_level;
   } sched_decision_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [CMD_W-1:0]  req_command;
   logic [PRIO_W-1:0] req_prio;
   logic [31:0]       req_delay_ticks;
   logic              rsp_valid;
   logic              rsp_ready;
   logic              rsp_switch_request;
   logic [PRIO_W-1:0] rsp_next_prio;
   logic [LOCK_W-1:0] rsp_lock_level;

   // Shadow copy of the scheduler state.
   logic [LEVELS-1:0] ready_map;
   logic [LEVELS-1:0] present_map;
   logic [31:0]       delay_count [LEVELS];
   logic [LOCK_W-1:0] lock_count;
   logic [PRIO_W-1:0] current_level;

   sched_decision_type awaited_decisions [$];
   int                 mismatches  = 0;
   int                 cycle_count = 0;
   bit                 idle_bursts = 1'b1;

   priority_bitmap_task_scheduler #(
      .PRIO_LEVELS (LEVELS),
      .DELAY_BITS  (DELAY_W)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_prio           (req_prio),
      .req_delay_ticks    (req_delay_ticks),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_switch_request (rsp_switch_request),
      .rsp_next_prio      (rsp_next_prio),
      .rsp_lock_level     (rsp_lock_level)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Picks the lowest ready level while unlocked; returns 1 on a switch.
   function automatic bit pick_ready_level();
      if (lock_count != '0 || ready_map == '0)
         return 1'b0;
      for (int lvl = 0; lvl < LEVELS; lvl++) begin
         if (ready_map[lvl]) begin
            if (PRIO_W'(lvl) == current_level)
               return 1'b0;
            current_level = PRIO_W'(lvl);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   task automatic reset_scheduler();
      ready_map     = '0;
      present_map   = '0;
      ready_map[IDLE_LEVEL]   = 1'b1;
      present_map[IDLE_LEVEL] = 1'b1;
      for (int i = 0; i < LEVELS; i++)
         delay_count[i] = '0;
      lock_count    = '0;
      current_level = IDLE_LEVEL;
   endtask

   task automatic advance_scheduler(input logic [CMD_W-1:0] cmd, input logic [PRIO_W-1:0] prio,
                                    input logic [31:0] ticks);
      sched_decision_type d;
      d.switch_request = 1'b0;
      case (cmd)
         CMD_CREATE: begin
            present_map[prio] = 1'b1;
            ready_map[prio]   = 1'b1;
            delay_count[prio] = '0;
         end
         CMD_DELAY: begin
            delay_count[current_level] = ticks;
            ready_map[current_level]   = 1'b0;
            d.switch_request = pick_ready_level();
         end
         CMD_TICK: begin
            for (int i = 0; i < LEVELS; i++) begin
               if (present_map[i]) begin
                  if (delay_count[i] != '0)
                     delay_count[i] = delay_count[i] - 32'd1;
                  else
                     ready_map[i] = 1'b1;
               end
            end
            d.switch_request = pick_ready_level();
         end
         CMD_LOCK: begin
            if (lock_count != LOCK_MAX)
               lock_count = lock_count + LOCK_W'(1);
         end
         CMD_UNLOCK: begin
            if (lock_count != '0) begin
               lock_count = lock_count - LOCK_W'(1);
               if (lock_count == '0)
                  d.switch_request = pick_ready_level();
            end
         end
         default: ;
      endcase
      d.next_prio  = current_level;
      d.lock_level = lock_count;
      awaited_decisions.push_back(d);
   endtask

   // Offers one command and returns once the block has taken it.
   task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [PRIO_W-1:0] prio,
                               input logic [31:0] ticks);
      if (idle_bursts && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat ($urandom_range(1, 4) - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid       = 1'b1;
      req_command     = cmd;
      req_prio        = prio;
      req_delay_ticks = ticks;
      do
         @(posedge clock);
      while (!req_ready);
      advance_scheduler(cmd, prio, ticks);
   endtask

   function automatic logic [31:0] random_ticks();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return $urandom();
         default: return $urandom_range(0, 6);
      endcase
   endfunction

   function automatic logic [CMD_W-1:0] pick_spare_command();
      return CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
   endfunction

   task automatic send_random_command();
      int                 pick;
      logic [CMD_W-1:0]   cmd;
      pick = $urandom_range(0, 99);
      if (pick < 20)
         cmd = CMD_CREATE;
      else if (pick < 40)
         cmd = CMD_DELAY;
      else if (pick < 70)
         cmd = CMD_TICK;
      else if (pick < 80)
         cmd = CMD_LOCK;
      else if (pick < 97)
         cmd = CMD_UNLOCK;
      else
         cmd = pick_spare_command();
      send_command(cmd, PRIO_W'($urandom_range(0, LEVELS - 1)), random_ticks());
   endtask

   // Receiver: random stall bursts while idling is enabled.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else if (idle_bursts && $urandom_range(0, 3) == 0) begin
            rsp_ready  = 1'b0;
            stall_left = $urandom_range(1, 4) - 1;
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_results
      sched_decision_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_decisions.size() == 0) begin
            $error("unexpected result transaction: next_prio %0d", rsp_next_prio);
            mismatches++;
         end else begin
            want = awaited_decisions.pop_front();
            if (rsp_switch_request !== want.switch_request) begin
               $error("switch_request: expected %0d, got %0d",
                      want.switch_request, rsp_switch_request);
               mismatches++;
            end
            if (rsp_next_prio !== want.next_prio) begin
               $error("next_prio: expected %0d, got %0d", want.next_prio, rsp_next_prio);
               mismatches++;
            end
            if (rsp_lock_level !== want.lock_level) begin
               $error("lock_level: expected %0d, got %0d", want.lock_level, rsp_lock_level);
               mismatches++;
            end
         end
      end
   end

   task automatic test_quiet_commands();
      send_command(CMD_SPARE_FIRST, '0, '0);
      send_command(CMD_SPARE_MID, 5'd10, 32'h5555_5555);
      send_command(CMD_SPARE_LAST, '1, '1);
      send_command(CMD_UNLOCK, '0, '0);
      send_command(CMD_TICK, '0, '0);
   endtask

   // The idle task delays itself so that no level is ready, then is renewed.
   task automatic test_idle_task();
      send_command(CMD_DELAY, '0, '1);
      send_command(CMD_TICK, '0, '0);
      send_command(CMD_CREATE, IDLE_LEVEL, '0);
      send_command(CMD_TICK, '0, '0);
   endtask

   task automatic test_preemption();
      send_command(CMD_CREATE, 5'd0, '0);
      send_command(CMD_CREATE, 5'd17, '1);
      send_command(CMD_TICK, '0, '0);
      send_command(CMD_DELAY, '0, '0);
      send_command(CMD_TICK, '0, '0);
      send_command(CMD_DELAY, '0, 32'd1);
      send_command(CMD_TICK, '0, '0);
      send_command(CMD_TICK, '0, '0);
   endtask

   // A delay while locked leaves the current level in place until unlock.
   task automatic test_lock_nesting();
      send_command(CMD_LOCK, '0, '0);
      send_command(CMD_DELAY, '0, 32'd3);
      send_command(CMD_TICK, '0, '0);
      send_command(CMD_LOCK, '0, '0);
      send_command(CMD_UNLOCK, '0, '0);
      send_command(CMD_UNLOCK, '0, '0);
   endtask

   task automatic test_lock_saturation();
      int locks_sent;
      locks_sent = 0;
      while (locks_sent < 260) begin
         if ($urandom_range(0, 4) == 0) begin
            send_random_command();
         end else begin
            send_command(CMD_LOCK, PRIO_W'($urandom()), $urandom());
            locks_sent++;
         end
      end
      while (lock_count != '0) begin
         if ($urandom_range(0, 4) == 0)
            send_random_command();
         else
            send_command(CMD_UNLOCK, PRIO_W'($urandom()), $urandom());
      end
   endtask

   task automatic test_random_traffic(input int count);
      repeat (count) send_random_command();
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_command     = '0;
      req_prio        = '0;
      req_delay_ticks = '0;
      reset_scheduler();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_quiet_commands();
      test_idle_task();
      test_preemption();
      test_lock_nesting();
      test_lock_saturation();
      test_random_traffic(590);
      // The closing stretch runs with both sides at full rate.
      idle_bursts = 1'b0;
      test_random_traffic(200);

      @(negedge clock);
      req_valid = 1'b0;
      while (awaited_decisions.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
